// ===== sv/qkc_pkg.sv =====
// ----------------------------------------------------------------------------
// qkc_pkg
// Types and constants for the quadrature knob decoder with click detection.
// ----------------------------------------------------------------------------
package qkc_pkg;

    localparam int unsigned LOCKOUT_W   = 16;
    localparam int unsigned COUNT_W     = 8;
    localparam int unsigned DELTA_W     = 7;
    localparam int unsigned POS_W       = 2;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 16;

    localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 16'd500;
    localparam logic [LOCKOUT_W-1:0] TIMER_MAX     = 16'hFFFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 8'sd127;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = -8'sd128;

    // Packed LSB-first: last member sits in bit 0.
    typedef struct packed {
        logic [2:0] pad;
        logic       take_click;
        logic       take_delta;
        logic       knob_level;
        logic       phase_b_level;
        logic       phase_a_level;
    } knob_in_t;

    typedef struct packed {
        logic [6:0]                pad;
        logic                      knob_pressed;
        logic                      click_seen;
        logic signed [DELTA_W-1:0] delta_steps;
    } knob_out_t;

endpackage

// ===== sv/quadrature_knob_with_click_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_knob_with_click_top
// Results are registered in the output register, or in the skid register.
// Throughput: one beat per cycle while the sink accepts; a two-entry result
// stage lets input continue for one beat while the sink stalls.
// Reset (aresetn, synchronous, active low) clears decoder state and sets the
// click lockout to 500.
// ----------------------------------------------------------------------------
module quadrature_knob_with_click_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [qkc_pkg::LOCKOUT_W-1:0]  cfg_wdata,    // click_lockout
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] phase_a_level, [1] phase_b_level, [2] knob_level,
    // [3] take_delta, [4] take_click, [7:5] zero
    input  logic [qkc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] delta_steps, [7] click_seen, [8] knob_pressed, [15:9] zero
    output logic [qkc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import qkc_pkg::*;

    logic [LOCKOUT_W-1:0]      lockout_reg;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      primed_reg;
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic [LOCKOUT_W-1:0]      timer_reg, timer_next;
    logic                      held_reg, held_next;
    logic                      pending_reg, pending_next;

    knob_out_t out_reg, skid_reg, res;
    logic      out_valid_reg, skid_valid_reg;

    knob_in_t            din;
    logic [POS_W-1:0]    pos, diff;
    logic                pressed;
    logic [LOCKOUT_W-1:0] timer_inc;
    logic                in_beat, out_free;

    assign din      = knob_in_t'(s_tdata);
    assign s_tready = !skid_valid_reg;
    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(out_reg);

    always_comb begin
        pos       = {~din.phase_b_level, din.phase_a_level ^ din.phase_b_level};
        pressed   = !din.knob_level;
        diff      = pos_reg - pos;
        pos_next  = pos_reg;
        count_next = count_reg;
        held_next  = held_reg;
        pending_next = pending_reg;
        res        = '0;

        if (!primed_reg) begin
            pos_next = pos;
        end else if (diff[0]) begin
            pos_next = pos;
            if (diff[1]) begin
                if (count_reg != COUNT_MAX) count_next = count_reg + 8'sd1;
            end else begin
                if (count_reg != COUNT_MIN) count_next = count_reg - 8'sd1;
            end
        end

        timer_inc  = (timer_reg == TIMER_MAX) ? timer_reg : timer_reg + 16'd1;
        timer_next = timer_inc;
        if (!pending_reg && (timer_inc > lockout_reg)) begin
            if (pressed) begin
                held_next = 1'b1;
            end else if (held_reg) begin
                held_next    = 1'b0;
                pending_next = 1'b1;
            end
        end

        if (din.take_delta) begin
            res.delta_steps = count_next[COUNT_W-1:1];
            count_next      = {{(COUNT_W-1){1'b0}}, count_next[0]};
        end

        if (din.take_click && pending_next) begin
            timer_next     = '0;
            pending_next   = 1'b0;
            res.click_seen = 1'b1;
        end
        res.knob_pressed = pressed;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lockout_reg    <= LOCKOUT_RESET;
            pos_reg        <= '0;
            primed_reg     <= 1'b0;
            count_reg      <= '0;
            timer_reg      <= '0;
            held_reg       <= 1'b0;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                lockout_reg <= cfg_wdata;
            end
            if (in_beat) begin
                pos_reg     <= pos_next;
                primed_reg  <= 1'b1;
                count_reg   <= count_next;
                timer_reg   <= timer_next;
                held_reg    <= held_next;
                pending_reg <= pending_next;
            end
            if (skid_valid_reg) begin
                if (m_tready) begin
                    out_reg        <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
            end else if (in_beat) begin
                if (out_free) begin
                    out_reg       <= res;
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= res;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/qkc_checker.sv =====
// ----------------------------------------------------------------------------
// qkc_checker
// Port-level checks for the quadrature knob decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qkc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [qkc_pkg::M_TDATA_W-1:0] m_tdata
);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_backpressure_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind quadrature_knob_with_click_top qkc_checker u_qkc_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadrature knob decoder with click detection: stream-level testbench
// A queue of ticks feeds a clocked driver; a clocked monitor checks each
// result beat against a cycle-free model of the decoder state. Phases at
// several click lockouts cover priming, count saturation, jumps by two
// and click timing, with random idling both sides.
// ----------------------------------------------------------------------------
module testbench;

    import qkc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_AT     = 100;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 10;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [LOCKOUT_W-1:0]   cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    // decoder model state
    logic [LOCKOUT_W-1:0]       lockout_q = LOCKOUT_RESET;
    logic [POS_W-1:0]           pos_q     = '0;
    logic                       primed_q  = 1'b0;
    logic signed [COUNT_W-1:0]  steps_q   = '0;
    logic [LOCKOUT_W-1:0]       timer_q   = '0;
    logic                       held_q    = 1'b0;
    logic                       click_q   = 1'b0;

    knob_in_t   tick_queue[$];
    knob_out_t  tick_results[$];
    knob_out_t  got_beat;
    knob_out_t  want_beat;

    logic [POS_W-1:0] gen_pos  = '0;
    logic             gen_knob = 1'b1;

    bit long_hold_done = 1'b0;
    int send_gap       = 0;
    int send_streak    = 0;
    int hold_left      = 0;
    int sink_streak    = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    quadrature_knob_with_click_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic knob_out_t decode_tick(knob_in_t t);
        knob_out_t         r;
        logic [POS_W-1:0]  pos;
        logic [POS_W-1:0]  diff;
        logic              pressed;
        r       = '0;
        pos     = {~t.phase_b_level, t.phase_a_level ^ t.phase_b_level};
        pressed = ~t.knob_level;
        if (!primed_q) begin
            pos_q    = pos;
            primed_q = 1'b1;
        end else begin
            diff = pos_q - pos;
            if (diff[0]) begin
                pos_q = pos;
                if (diff[1]) begin
                    if (steps_q != COUNT_MAX) steps_q = steps_q + 8'sd1;
                end else begin
                    if (steps_q != COUNT_MIN) steps_q = steps_q - 8'sd1;
                end
            end
        end
        if (timer_q != TIMER_MAX) timer_q = timer_q + 16'd1;
        if (!click_q && timer_q > lockout_q) begin
            if (!held_q && pressed) held_q = 1'b1;
            if (held_q && !pressed) begin
                held_q  = 1'b0;
                click_q = 1'b1;
            end
        end
        if (t.take_delta) begin
            r.delta_steps = steps_q[COUNT_W-1:1];
            steps_q       = {7'b0, steps_q[0]};
        end
        if (t.take_click && click_q) begin
            timer_q      = '0;
            click_q      = 1'b0;
            r.click_seen = 1'b1;
        end
        r.knob_pressed = pressed;
        return r;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_idle(inout int streak);
        int r;
        if (streak > 0) begin
            streak--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            streak = $urandom_range(10, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    task automatic push_raw(input logic [4:0] bits);
        knob_in_t t;
        t        = '0;
        t[4:0]   = bits;
        gen_pos  = {~t.phase_b_level, t.phase_a_level ^ t.phase_b_level};
        gen_knob = t.knob_level;
        tick_queue.push_back(t);
    endtask

    task automatic push_tick(input logic [POS_W-1:0] pos, input logic knob,
                             input logic td, input logic tc);
        push_raw({tc, td, knob, ~pos[1], ~pos[1] ^ pos[0]});
    endtask

    task automatic queue_spin(input bit up, input int len);
        for (int k = 0; k < len; k++) begin
            push_tick(up ? gen_pos + 2'd1 : gen_pos - 2'd1, gen_knob, 1'b0, 1'b0);
        end
        push_tick(gen_pos, gen_knob, 1'b1, 1'b0);
    endtask

    task automatic queue_mixed(input int n);
        int added;
        int kind;
        int len;
        int rel;
        bit up;
        added = 0;
        while (added < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                len = $urandom_range(1, 12);
                up  = 1'($urandom_range(0, 1));
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 5) == 0) up = !up;
                    push_tick(up ? gen_pos + 2'd1 : gen_pos - 2'd1, gen_knob,
                              $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
                end
                added += len;
            end else if (kind < 75) begin
                // press, release, then perhaps collect the click
                len = $urandom_range(1, 4);
                rel = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 3) == 0) gen_pos = gen_pos + 2'd1;
                    push_tick(gen_pos, 1'b0, $urandom_range(0, 9) == 0,
                              $urandom_range(0, 9) == 0);
                end
                for (int k = 0; k < rel; k++) begin
                    push_tick(gen_pos, 1'b1, $urandom_range(0, 9) == 0,
                              1'($urandom_range(0, 1)));
                end
                added += len + rel;
            end else if (kind < 76) begin
                len = $urandom_range(130, 140);
                queue_spin(1'($urandom_range(0, 1)), len);
                added += len + 1;
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) push_raw(5'($urandom_range(0, 31)));
                added += len;
            end
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (tick_queue.size() != 0 || s_tvalid || tick_results.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_lockout(input logic [LOCKOUT_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        lockout_q  = value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                tick_results.push_back(decode_tick(s_tdata));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    s_tdata  <= tick_queue.pop_front();
                    s_tvalid <= 1'b1;
                    send_gap  = pick_idle(send_streak);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_beat = m_tdata;
                results_seen++;
                if (tick_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result beat %h at %0t", m_tdata, $realtime);
                end else begin
                    want_beat = tick_results.pop_front();
                    if (got_beat.delta_steps  !== want_beat.delta_steps ||
                        got_beat.click_seen   !== want_beat.click_seen  ||
                        got_beat.knob_pressed !== want_beat.knob_pressed) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("beat %0d: expected delta %0d click %0b pressed %0b",
                                     results_seen, want_beat.delta_steps,
                                     want_beat.click_seen, want_beat.knob_pressed);
                            $display("beat %0d: got delta %0d click %0b pressed %0b",
                                     results_seen, got_beat.delta_steps,
                                     got_beat.click_seen, got_beat.knob_pressed);
                        end
                    end
                end
            end
            // one long hold-off so the result stage backs up into the input
            if (hold_left == 0 && !long_hold_done && results_seen >= HOLD_AT) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
            end else if (hold_left == 0 && m_tready) begin
                hold_left = pick_idle(sink_streak);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, reset lockout
        push_tick(2'd2, 1'b0, 1'b1, 1'b1);   // priming tick with both requests
        push_tick(2'd3, 1'b1, 1'b0, 1'b0);
        push_tick(2'd0, 1'b1, 1'b0, 1'b0);
        push_tick(2'd1, 1'b1, 1'b0, 1'b0);
        push_tick(2'd2, 1'b1, 1'b1, 1'b0);
        push_tick(2'd1, 1'b0, 1'b0, 1'b1);   // click request, none pending
        push_tick(2'd0, 1'b0, 1'b0, 1'b0);
        push_tick(2'd3, 1'b1, 1'b1, 1'b0);   // negative count read, odd bit kept
        push_tick(2'd1, 1'b1, 1'b0, 1'b0);   // jump by two
        push_tick(2'd1, 1'b1, 1'b1, 1'b1);
        push_tick(2'd2, 1'b0, 1'b0, 1'b0);
        push_tick(2'd0, 1'b1, 1'b0, 1'b0);   // jump by two
        push_raw(5'h1F);
        push_raw(5'h00);
        push_raw(5'h0A);
        push_raw(5'h15);
        push_tick(gen_pos, 1'b1, 1'b1, 1'b1);
        wait_idle();

        write_lockout(16'd0);
        queue_spin(1'b1, 140);               // saturate high
        queue_mixed(80);
        wait_idle();

        write_lockout(16'd3);
        queue_spin(1'b0, 140);               // saturate low
        queue_mixed(60);
        wait_idle();

        write_lockout(16'hFFFF);             // clicks can never qualify
        queue_mixed(30);
        wait_idle();

        write_lockout(16'($urandom_range(4, 40)));
        queue_mixed(60);
        wait_idle();

        write_lockout(16'd1);
        queue_mixed(40);
        wait_idle();

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && tick_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
